/* sv/mkcld_pkg.sv */
`default_nettype none

package mkcld_pkg;

   // Default sizing
   localparam int NUM_PORTS_DEF  = 8;
   localparam int PIN_BITS_DEF   = 32;
   localparam int MAX_CLICKS_DEF = 15;

   // Fixed field widths
   localparam int PORT_W  = 3;
   localparam int CODE_W  = 32;
   localparam int TIME_W  = 16;
   localparam int CLICK_W = 4;
   localparam int EVENT_W = 5;
   localparam int CSR_AW  = 2;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_TICK_PERIOD   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_RELEASE_TMO   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_LONG_PRESS    = 2'd2;

   // Register reset values
   localparam logic [TIME_W-1:0] TICK_PERIOD_RST = 16'd10;
   localparam logic [TIME_W-1:0] RELEASE_TMO_RST = 16'd300;
   localparam logic [TIME_W-1:0] LONG_PRESS_RST  = 16'd1000;

   // Stored event code for a long press (0 none, 1..15 clicks)
   localparam logic [EVENT_W-1:0] EVENT_LONG = 5'd16;

   // Result output queue
   localparam int OUT_DEPTH = 4;
   localparam int OUT_AW    = 2;

   typedef struct packed {
      logic [PORT_W-1:0]  port_out;
      logic               released;
      logic [CODE_W-1:0]  key_code;
      logic [TIME_W-1:0]  held_time;
      logic [CLICK_W-1:0] click_count;
      logic               long_press;
   } rsp_beat_type;

endpackage

`default_nettype wire

/* sv/mkcld_ram.sv */
`default_nettype none

module mkcld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* sv/multi_key_click_longpress_detector.sv */
`default_nettype none

// Multi-key click and long-press detector.
// req channel: one beat per scan tick of one key port (port index, sampled
// pin levels, idle mask). An idle mask of zero or a port index past the last
// port is consumed with no effect. rsp channel: zero or one beat per tick;
// while a key is held each tick after the first reports the inverted pins and
// elapsed time (released = 0); once the release has lasted the timeout a
// final beat (released = 1) carries the click count or the long-press flag.
// csr port: plain write (csr_we, csr_index, csr_wdata), no read-back; write
// only while idle.
// A request beat is registered in the update stage, then written to the queue.
// Throughput: one request beat per cycle while req_stall is low. Per-port
// state sits in a single-port-write RAM with registered read; the tick reads
// at accept, updates and writes back the next cycle, and a one-entry bypass
// covers back-to-back ticks on the same port.
// Reset clears the registers to their defaults and marks every port's state
// as zero through per-port valid bits; no clearing pass is needed.
// rsp_stall: results go through a four-beat queue; req_stall rises once the
// queue plus the tick in flight hold three beats, so no beat is ever dropped.

module multi_key_click_longpress_detector #(
   parameter int NUM_PORTS  = mkcld_pkg::NUM_PORTS_DEF,
   parameter int PIN_BITS   = mkcld_pkg::PIN_BITS_DEF,
   parameter int MAX_CLICKS = mkcld_pkg::MAX_CLICKS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [mkcld_pkg::PORT_W-1:0] req_port_index,
   input  wire logic [mkcld_pkg::CODE_W-1:0] req_pin_levels,
   input  wire logic [mkcld_pkg::CODE_W-1:0] req_idle_mask,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [mkcld_pkg::PORT_W-1:0]     rsp_port_out,
   output logic                             rsp_released,
   output logic [mkcld_pkg::CODE_W-1:0]     rsp_key_code,
   output logic [mkcld_pkg::TIME_W-1:0]     rsp_held_time,
   output logic [mkcld_pkg::CLICK_W-1:0]    rsp_click_count,
   output logic                             rsp_long_press,
   // configuration
   input  wire logic                        csr_we,
   input  wire logic [mkcld_pkg::CSR_AW-1:0] csr_index,
   input  wire logic [mkcld_pkg::TIME_W-1:0] csr_wdata
);

   import mkcld_pkg::*;

   localparam int PORT_AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

   typedef struct packed {
      logic                key_is_down;
      logic [PIN_BITS-1:0] press_pattern;
      logic [TIME_W-1:0]   elapsed_ms;
      logic                release_seen;
      logic [CLICK_W-1:0]  running_clicks;
      logic [PIN_BITS-1:0] reported_code;
      logic [TIME_W-1:0]   reported_time;
      logic [EVENT_W-1:0]  reported_event;
   } port_state_type;

   localparam int ST_W = $bits(port_state_type);

   // ---------------- configuration registers ----------------
   logic [TIME_W-1:0] tick_period_ff;
   logic [TIME_W-1:0] release_tmo_ff;
   logic [TIME_W-1:0] long_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= TICK_PERIOD_RST;
         release_tmo_ff <= RELEASE_TMO_RST;
         long_limit_ff  <= LONG_PRESS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TICK_PERIOD: tick_period_ff <= csr_wdata;
            CSR_RELEASE_TMO: release_tmo_ff <= csr_wdata;
            CSR_LONG_PRESS:  long_limit_ff  <= csr_wdata;
            default: ;  // unused index
         endcase
      end
   end

   // ---------------- accept stage ----------------
   logic                req_accept;
   logic                req_in_range;
   logic [PIN_BITS-1:0] req_mask;
   logic [PIN_BITS-1:0] req_levels;
   logic                req_keep;
   logic [PORT_AW-1:0]  req_addr;

   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = ({29'd0, req_port_index} < 32'(NUM_PORTS));
   assign req_mask     = req_idle_mask[PIN_BITS-1:0];
   assign req_levels   = req_pin_levels[PIN_BITS-1:0] & req_mask;
   assign req_keep     = req_accept && req_in_range && (req_mask != '0);
   assign req_addr     = PORT_AW'(req_port_index);

   // ---------------- update stage registers ----------------
   logic                s1_valid_ff;
   logic [PORT_AW-1:0]  s1_port_ff;
   logic [PIN_BITS-1:0] s1_levels_ff;
   logic [PIN_BITS-1:0] s1_mask_ff;
   logic                rd_valid_ff;

   logic [NUM_PORTS-1:0] entry_valid_ff;   // port state written since reset
   logic                 byp_valid_ff;     // last write-back, for same-port ticks
   logic [PORT_AW-1:0]   byp_port_ff;
   port_state_type       byp_data_ff;

   logic [ST_W-1:0]      ram_rdata;
   port_state_type       st_cur;
   port_state_type       st_nxt;
   logic                 s1_emit;
   logic                 s1_final;
   rsp_beat_type         s1_beat;

   mkcld_ram #(
      .WIDTH (ST_W),
      .DEPTH (NUM_PORTS)
   ) u_state_ram (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_port_ff),
      .wdata (st_nxt),
      .raddr (req_addr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         entry_valid_ff <= '0;
         byp_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= req_keep;
         if (s1_valid_ff) begin
            entry_valid_ff[s1_port_ff] <= 1'b1;
            byp_valid_ff               <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_keep) begin
         s1_port_ff   <= req_addr;
         s1_levels_ff <= req_levels;
         s1_mask_ff   <= req_mask;
         rd_valid_ff  <= entry_valid_ff[req_addr];
      end
      if (s1_valid_ff) begin
         byp_port_ff <= s1_port_ff;
         byp_data_ff <= st_nxt;
      end
   end

   // current state: bypass beats RAM, unwritten entries read as zero
   always_comb begin
      if (byp_valid_ff && (byp_port_ff == s1_port_ff)) begin
         st_cur = byp_data_ff;
      end else if (rd_valid_ff) begin
         st_cur = port_state_type'(ram_rdata);
      end else begin
         st_cur = '0;
      end
   end

   // per-tick state update
   always_comb begin
      logic [TIME_W-1:0] el_sum;
      logic [TIME_W:0]   deadline;
      logic              all_up;
      st_nxt   = st_cur;
      s1_emit  = 1'b0;
      s1_final = 1'b0;
      el_sum   = st_cur.elapsed_ms + tick_period_ff;
      deadline = {1'b0, st_cur.reported_time} + {1'b0, release_tmo_ff};
      all_up   = (s1_levels_ff == s1_mask_ff);

      if (!st_cur.key_is_down) begin
         // up state: arm on the first pressed tick
         st_nxt.release_seen   = 1'b0;
         st_nxt.running_clicks = '0;
         st_nxt.press_pattern  = s1_levels_ff;
         if (!all_up) begin
            st_nxt.key_is_down    = 1'b1;
            st_nxt.running_clicks = CLICK_W'(1);
         end
      end else begin
         st_nxt.elapsed_ms = el_sum;
         if (all_up) begin
            st_nxt.release_seen = 1'b1;
            if ({1'b0, el_sum} >= deadline) begin
               // release lasted long enough: close the sequence
               s1_emit  = 1'b1;
               s1_final = 1'b1;
               st_nxt.release_seen = 1'b0;
               st_nxt.key_is_down  = 1'b0;
               st_nxt.elapsed_ms   = '0;
               if (st_cur.reported_time > long_limit_ff) begin
                  st_nxt.reported_event = EVENT_LONG;
               end else begin
                  st_nxt.reported_event = {1'b0, st_cur.running_clicks};
               end
            end
         end else begin
            s1_emit              = 1'b1;
            st_nxt.reported_code = ~s1_levels_ff;
            st_nxt.reported_time = el_sum;
         end
         // same pattern pressed again after a release: one more click
         if (!s1_final && (s1_levels_ff == st_cur.press_pattern) &&
             st_nxt.release_seen) begin
            if (st_cur.running_clicks < CLICK_W'(MAX_CLICKS)) begin
               st_nxt.running_clicks = st_cur.running_clicks + CLICK_W'(1);
            end
            st_nxt.release_seen = 1'b0;
         end
      end
   end

   always_comb begin
      s1_beat.port_out  = PORT_W'(s1_port_ff);
      s1_beat.released  = s1_final;
      s1_beat.key_code  = CODE_W'(st_nxt.reported_code);
      s1_beat.held_time = st_nxt.reported_time;
      if (st_nxt.reported_event == EVENT_LONG) begin
         s1_beat.click_count = '0;
         s1_beat.long_press  = 1'b1;
      end else begin
         s1_beat.click_count = st_nxt.reported_event[CLICK_W-1:0];
         s1_beat.long_press  = 1'b0;
      end
   end

   // ---------------- result queue ----------------
   rsp_beat_type      outq_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] outq_wr_ff;
   logic [OUT_AW-1:0] outq_rd_ff;
   logic [OUT_AW:0]   outq_cnt_ff;
   logic              outq_push;
   logic              outq_pop;
   rsp_beat_type      outq_head;

   assign outq_push = s1_valid_ff && s1_emit;
   assign outq_pop  = rsp_valid && !rsp_stall;
   assign outq_head = outq_ff[outq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         outq_wr_ff  <= '0;
         outq_rd_ff  <= '0;
         outq_cnt_ff <= '0;
      end else begin
         if (outq_push) begin
            outq_wr_ff <= outq_wr_ff + OUT_AW'(1);
         end
         if (outq_pop) begin
            outq_rd_ff <= outq_rd_ff + OUT_AW'(1);
         end
         outq_cnt_ff <= outq_cnt_ff + (OUT_AW + 1)'(outq_push) - (OUT_AW + 1)'(outq_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (outq_push) begin
         outq_ff[outq_wr_ff] <= s1_beat;
      end
   end

   // room for the tick in flight and one more
   assign req_stall = ((outq_cnt_ff + (OUT_AW + 1)'(s1_valid_ff)) >= (OUT_AW + 1)'(OUT_DEPTH - 1));

   assign rsp_valid       = (outq_cnt_ff != '0);
   assign rsp_port_out    = outq_head.port_out;
   assign rsp_released    = outq_head.released;
   assign rsp_key_code    = outq_head.key_code;
   assign rsp_held_time   = outq_head.held_time;
   assign rsp_click_count = outq_head.click_count;
   assign rsp_long_press  = outq_head.long_press;

endmodule

`default_nettype wire

/* sv/mkcld_checker.sv */
`default_nettype none

module mkcld_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_click_count,
   input wire logic        rsp_long_press
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // no result beat right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // long press never carries a click count
   a_long_clicks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_long_press |-> rsp_click_count == 4'd0)
      else $error("long press with click count");

   // an empty result side only fills from a request that passed the update stage
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("rsp beat without request");

endmodule

bind multi_key_click_longpress_detector mkcld_checker u_mkcld_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_click_count (rsp_click_count),
   .rsp_long_press  (rsp_long_press)
);

`default_nettype wire
